// ===== src/pfm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_pkg - shared types and constants of the power factor meter
// window sizing, shared arithmetic unit interface, sequencer states and steps
// ----------------------------------------------------------------------------
package pfm_pkg;

    localparam int ADC_BITS    = 12;
    localparam int MAX_SAMPLES = 4096;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = ADC_BITS + $clog2(MAX_SAMPLES);
    localparam int SQ_W        = 2 * ADC_BITS + $clog2(MAX_SAMPLES);
    localparam int AW          = 64;
    localparam int STEP_W      = 5;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT,
        OP_SUB
    } arith_op_t;

    typedef struct packed {
        logic            go;
        arith_op_t       op;
        logic [AW-1:0]   a;
        logic [AW-1:0]   b;
    } arith_req_t;

    typedef struct packed {
        logic            done;
        logic            neg;
        logic [AW-1:0]   res;
    } arith_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [STEP_W-1:0] {
        SP_U_NSQ,
        SP_U_SS,
        SP_U_VAR,
        SP_U_SQRT,
        SP_U_RMS,
        SP_I_NSQ,
        SP_I_SS,
        SP_I_VAR,
        SP_I_SQRT,
        SP_I_RMS,
        SP_X_NP,
        SP_X_SS,
        SP_X_COV,
        SP_APP,
        SP_NN,
        SP_PWR,
        SP_PQ8,
        SP_PF,
        SP_U_MEAN,
        SP_I_MEAN
    } step_t;

endpackage
`default_nettype wire

// ===== src/pfm_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_accum - window accumulators
// registers each sample pair, then adds sums, squares and cross product
// ----------------------------------------------------------------------------
module pfm_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [pfm_pkg::ADC_BITS-1:0]  u_in,
    input  logic [pfm_pkg::ADC_BITS-1:0]  i_in,
    input  logic                          clear,
    output logic [pfm_pkg::CNT_W-1:0]     n,
    output logic [pfm_pkg::SUM_W-1:0]     su,
    output logic [pfm_pkg::SUM_W-1:0]     si,
    output logic [pfm_pkg::SQ_W-1:0]      suu,
    output logic [pfm_pkg::SQ_W-1:0]      sii,
    output logic [pfm_pkg::SQ_W-1:0]      sui,
    output logic                          ovf
);
    import pfm_pkg::*;

    logic                  stage_vld_reg, stage_vld_next;
    logic [ADC_BITS-1:0]   u_reg, u_next, i_reg, i_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SUM_W-1:0]      su_reg, su_next, si_reg, si_next;
    logic [SQ_W-1:0]       suu_reg, suu_next, sii_reg, sii_next, sui_reg, sui_next;
    logic                  ovf_reg, ovf_next;
    logic [2*ADC_BITS-1:0] uu, ii, ui;

    assign uu = u_reg * u_reg;
    assign ii = i_reg * i_reg;
    assign ui = u_reg * i_reg;

    always_comb
    begin
        stage_vld_next = take;
        u_next         = take ? u_in : u_reg;
        i_next         = take ? i_in : i_reg;
        cnt_next       = cnt_reg;
        su_next        = su_reg;
        si_next        = si_reg;
        suu_next       = suu_reg;
        sii_next       = sii_reg;
        sui_next       = sui_reg;
        ovf_next       = ovf_reg;
        if (clear)
        begin
            cnt_next = '0;
            su_next  = '0;
            si_next  = '0;
            suu_next = '0;
            sii_next = '0;
            sui_next = '0;
            ovf_next = 1'b0;
        end
        else if (stage_vld_reg)
        begin
            if (cnt_reg < CNT_W'(MAX_SAMPLES))
            begin
                cnt_next = cnt_reg + 1'b1;
                su_next  = su_reg + SUM_W'(u_reg);
                si_next  = si_reg + SUM_W'(i_reg);
                suu_next = suu_reg + SQ_W'(uu);
                sii_next = sii_reg + SQ_W'(ii);
                sui_next = sui_reg + SQ_W'(ui);
            end
            else
            begin
                // window full: pair dropped
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            cnt_reg       <= '0;
            su_reg        <= '0;
            si_reg        <= '0;
            suu_reg       <= '0;
            sii_reg       <= '0;
            sui_reg       <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= stage_vld_next;
            cnt_reg       <= cnt_next;
            su_reg        <= su_next;
            si_reg        <= si_next;
            suu_reg       <= suu_next;
            sii_reg       <= sii_next;
            sui_reg       <= sui_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= u_next;
        i_reg <= i_next;
    end

    assign n   = cnt_reg;
    assign su  = su_reg;
    assign si  = si_reg;
    assign suu = suu_reg;
    assign sii = sii_reg;
    assign sui = sui_reg;
    assign ovf = ovf_reg;

endmodule
`default_nettype wire

// ===== src/pfm_arith.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_arith - shared iterative arithmetic unit
// shift-add multiply, restoring divide, digit sqrt, one bit a cycle; subtract
// ----------------------------------------------------------------------------
module pfm_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  pfm_pkg::arith_req_t req,
    output pfm_pkg::arith_rsp_t rsp
);
    import pfm_pkg::*;

    localparam int ITER_W = $clog2(AW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              neg_reg, neg_next;
    arith_op_t         op_reg, op_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]     acc_reg, acc_next, x_reg, x_next, y_reg, y_next;
    logic [AW:0]       rem_sh, sq_sh, sq_trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        rem_sh    = {acc_reg, x_reg[AW-1]};
        sq_sh     = {acc_reg[AW-2:0], x_reg[AW-1:AW-2]};
        sq_trial  = {y_reg[AW-2:0], 2'b01};
        if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            unique case (op_reg)
                OP_MUL:
                begin
                    if (y_reg[0])
                    begin
                        acc_next = acc_reg + x_reg;
                    end
                    x_next = x_reg << 1;
                    y_next = y_reg >> 1;
                end
                OP_DIV:
                begin
                    if (rem_sh >= {1'b0, y_reg})
                    begin
                        acc_next = AW'(rem_sh - {1'b0, y_reg});
                        x_next   = {x_reg[AW-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = rem_sh[AW-1:0];
                        x_next   = {x_reg[AW-2:0], 1'b0};
                    end
                end
                OP_SQRT:
                begin
                    if (sq_sh >= sq_trial)
                    begin
                        acc_next = AW'(sq_sh - sq_trial);
                        y_next   = {y_reg[AW-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = sq_sh[AW-1:0];
                        y_next   = {y_reg[AW-2:0], 1'b0};
                    end
                    x_next = x_reg << 2;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.go)
        begin
            op_next  = req.op;
            acc_next = '0;
            x_next   = req.a;
            y_next   = req.b;
            unique case (req.op)
                OP_MUL, OP_DIV:
                begin
                    cnt_next  = ITER_W'(AW);
                    busy_next = 1'b1;
                end
                OP_SQRT:
                begin
                    y_next    = '0;
                    cnt_next  = ITER_W'(AW / 2);
                    busy_next = 1'b1;
                end
                OP_SUB:
                begin
                    // magnitude of a - b, sign kept apart
                    if (req.a >= req.b)
                    begin
                        acc_next = req.a - req.b;
                        neg_next = 1'b0;
                    end
                    else
                    begin
                        acc_next = req.b - req.a;
                        neg_next = 1'b1;
                    end
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        rsp.neg  = neg_reg;
        unique case (op_reg)
            OP_MUL:  rsp.res = acc_reg;
            OP_DIV:  rsp.res = x_reg;
            OP_SQRT: rsp.res = y_reg;
            OP_SUB:  rsp.res = acc_reg;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/pfm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_ctrl - end-of-window sequencer
// steps the shared unit through the result program and holds the results
// ----------------------------------------------------------------------------
module pfm_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         last_go,
    input  logic [pfm_pkg::CNT_W-1:0]    n,
    input  logic [pfm_pkg::SUM_W-1:0]    su,
    input  logic [pfm_pkg::SUM_W-1:0]    si,
    input  logic [pfm_pkg::SQ_W-1:0]     suu,
    input  logic [pfm_pkg::SQ_W-1:0]     sii,
    input  logic [pfm_pkg::SQ_W-1:0]     sui,
    input  pfm_pkg::arith_rsp_t          rsp,
    output pfm_pkg::arith_req_t          req,
    output logic                         busy,
    output logic                         clear,
    output logic                         done,
    output logic [15:0]                  u_mean,
    output logic [15:0]                  i_mean,
    output logic [14:0]                  u_rms,
    output logic [14:0]                  i_rms,
    output logic signed [23:0]           real_power,
    output logic [22:0]                  apparent_power,
    output logic signed [15:0]           power_factor,
    output logic                         undefined_flag
);
    import pfm_pkg::*;

    localparam int RMS_W = 15;
    localparam int D_W   = 2 * RMS_W;
    localparam int MAG_W = 2 * SUM_W;
    localparam int NN_W  = 2 * CNT_W;
    localparam int P_W   = 23;
    localparam logic [AW-1:0] PF_POS_MAX = AW'(32767);
    localparam logic [AW-1:0] PF_NEG_MAX = AW'(32768);

    ctrl_state_t      state_reg, state_next;
    step_t            step_reg, step_next;
    logic [AW-1:0]    r0_reg, r0_next, r1_reg, r1_next;
    logic [RMS_W-1:0] urms_reg, urms_next, irms_reg, irms_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic [D_W-1:0]   d_reg, d_next;
    logic [NN_W-1:0]  nn_reg, nn_next;
    logic [P_W-1:0]   p_reg, p_next;
    logic [15:0]      pf_reg, pf_next, umean_reg, umean_next, imean_reg, imean_next;
    logic             undef;

    assign undef = (d_reg[D_W-1:8] == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (last_go) state_next = ST_LAST;
            ST_LAST:  state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = (step_reg == SP_I_MEAN) ? ST_DONE : ST_ISSUE;
                end
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        busy   = (state_reg != ST_IDLE);
        clear  = (state_reg == ST_DONE);
        done   = (state_reg == ST_DONE);
        req.go = (state_reg == ST_ISSUE);
    end

    // operand selection per program step
    always_comb
    begin
        req.op = OP_MUL;
        req.a  = '0;
        req.b  = '0;
        unique case (step_reg)
            SP_U_NSQ:  begin req.op = OP_MUL;  req.a = AW'(n);  req.b = AW'(suu); end
            SP_U_SS:   begin req.op = OP_MUL;  req.a = AW'(su); req.b = AW'(su);  end
            SP_U_VAR:  begin req.op = OP_SUB;  req.a = r0_reg;  req.b = r1_reg;   end
            SP_U_SQRT: begin req.op = OP_SQRT; req.a = {r0_reg[AW-9:0], 8'd0};    end
            SP_U_RMS:  begin req.op = OP_DIV;  req.a = r0_reg;  req.b = AW'(n);   end
            SP_I_NSQ:  begin req.op = OP_MUL;  req.a = AW'(n);  req.b = AW'(sii); end
            SP_I_SS:   begin req.op = OP_MUL;  req.a = AW'(si); req.b = AW'(si);  end
            SP_I_VAR:  begin req.op = OP_SUB;  req.a = r0_reg;  req.b = r1_reg;   end
            SP_I_SQRT: begin req.op = OP_SQRT; req.a = {r0_reg[AW-9:0], 8'd0};    end
            SP_I_RMS:  begin req.op = OP_DIV;  req.a = r0_reg;  req.b = AW'(n);   end
            SP_X_NP:   begin req.op = OP_MUL;  req.a = AW'(n);  req.b = AW'(sui); end
            SP_X_SS:   begin req.op = OP_MUL;  req.a = AW'(su); req.b = AW'(si);  end
            SP_X_COV:  begin req.op = OP_SUB;  req.a = r0_reg;  req.b = r1_reg;   end
            SP_APP:
            begin
                req.op = OP_MUL;
                req.a  = AW'(urms_reg);
                req.b  = AW'(irms_reg);
            end
            SP_NN:     begin req.op = OP_MUL;  req.a = AW'(n);  req.b = AW'(n);   end
            SP_PWR:
            begin
                req.op = OP_DIV;
                req.a  = AW'(mag_reg);
                req.b  = AW'(nn_reg);
            end
            SP_PQ8:
            begin
                req.op = OP_DIV;
                req.a  = {AW'(mag_reg) << 8};
                req.b  = AW'(nn_reg);
            end
            SP_PF:
            begin
                req.op = OP_DIV;
                req.a  = r0_reg << 15;
                req.b  = AW'(d_reg);
            end
            SP_U_MEAN:
            begin
                req.op = OP_DIV;
                req.a  = AW'(su) << 4;
                req.b  = AW'(n);
            end
            SP_I_MEAN:
            begin
                req.op = OP_DIV;
                req.a  = AW'(si) << 4;
                req.b  = AW'(n);
            end
            default:   begin req.op = OP_MUL; end
        endcase
    end

    // write back of unit results
    always_comb
    begin
        step_next  = step_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        urms_next  = urms_reg;
        irms_next  = irms_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        d_next     = d_reg;
        nn_next    = nn_reg;
        p_next     = p_reg;
        pf_next    = pf_reg;
        umean_next = umean_reg;
        imean_next = imean_reg;
        if (state_reg == ST_DONE)
        begin
            step_next = SP_U_NSQ;
        end
        else if (state_reg == ST_WAIT && rsp.done)
        begin
            step_next = step_t'(step_reg + 1'b1);
            unique case (step_reg)
                SP_U_NSQ, SP_U_SQRT, SP_I_NSQ, SP_I_SQRT, SP_X_NP, SP_PQ8:
                    r0_next = rsp.res;
                SP_U_SS, SP_I_SS, SP_X_SS:
                    r1_next = rsp.res;
                SP_U_VAR, SP_I_VAR:
                    r0_next = rsp.neg ? '0 : rsp.res;
                SP_U_RMS:  urms_next = rsp.res[RMS_W-1:0];
                SP_I_RMS:  irms_next = rsp.res[RMS_W-1:0];
                SP_X_COV:
                begin
                    mag_next = rsp.res[MAG_W-1:0];
                    neg_next = rsp.neg;
                end
                SP_APP:    d_next  = rsp.res[D_W-1:0];
                SP_NN:     nn_next = rsp.res[NN_W-1:0];
                SP_PWR:    p_next  = rsp.res[P_W-1:0];
                SP_PF:
                begin
                    // saturate to signed Q1.15, zero when apparent power is zero
                    if (undef)
                    begin
                        pf_next = '0;
                    end
                    else if (neg_reg)
                    begin
                        pf_next = (rsp.res > PF_NEG_MAX) ? 16'h8000 : 16'(AW'(0) - rsp.res);
                    end
                    else
                    begin
                        pf_next = (rsp.res > PF_POS_MAX) ? 16'h7FFF : rsp.res[15:0];
                    end
                end
                SP_U_MEAN: umean_next = rsp.res[15:0];
                SP_I_MEAN: imean_next = rsp.res[15:0];
                default:   step_next = SP_U_NSQ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= SP_U_NSQ;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        urms_reg  <= urms_next;
        irms_reg  <= irms_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        d_reg     <= d_next;
        nn_reg    <= nn_next;
        p_reg     <= p_next;
        pf_reg    <= pf_next;
        umean_reg <= umean_next;
        imean_reg <= imean_next;
    end

    assign u_mean         = umean_reg;
    assign i_mean         = imean_reg;
    assign u_rms          = urms_reg;
    assign i_rms          = irms_reg;
    assign real_power     = $signed(neg_reg ? 24'(24'd0 - 24'(p_reg)) : 24'(p_reg));
    assign apparent_power = {1'b0, d_reg[D_W-1:8]};
    assign power_factor   = $signed(pf_reg);
    assign undefined_flag = undef;

endmodule
`default_nettype wire

// ===== src/ac_power_factor_meter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ac_power_factor_meter_top - true rms, real/apparent power and power factor
// accumulates sample pairs, then works out the window results iteratively
// ----------------------------------------------------------------------------
//  channel   handshake            words
//  sample    start / busy         u_sample, i_sample, last_sample
//  result    done (1-cycle strobe) u_mean .. window_count
//
//  a non-last sample word is taken every cycle while busy is low
//  a last word raises busy while one shared bit-serial unit runs the 20
//  steps of the result program (multiplies, divides, square roots and
//  subtracts), with a state each to enter and leave
//  the result ports are valid only in the done cycle, the sums clear after it
//  the receiver cannot stall: results are lost if not taken on done
//  reset is asynchronous, active low, and clears all sums and control
// ----------------------------------------------------------------------------
module ac_power_factor_meter_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [11:0]         u_sample,
    input  logic [11:0]         i_sample,
    input  logic                last_sample,
    output logic                done,
    output logic [15:0]         u_mean,
    output logic [15:0]         i_mean,
    output logic [14:0]         u_rms,
    output logic [14:0]         i_rms,
    output logic signed [23:0]  real_power,
    output logic [22:0]         apparent_power,
    output logic signed [15:0]  power_factor,
    output logic                undefined_flag,
    output logic                overflow_flag,
    output logic [12:0]         window_count
);
    import pfm_pkg::*;

    logic             take;
    logic             last_go;
    logic             clear;
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] su, si;
    logic [SQ_W-1:0]  suu, sii, sui;
    arith_req_t       req;
    arith_rsp_t       rsp;

    // word accepted when start meets an idle block
    assign take    = start & ~busy;
    assign last_go = take & last_sample;

    // running sums of the window
    pfm_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .u_in  (u_sample[ADC_BITS-1:0]),
        .i_in  (i_sample[ADC_BITS-1:0]),
        .clear (clear),
        .n     (n),
        .su    (su),
        .si    (si),
        .suu   (suu),
        .sii   (sii),
        .sui   (sui),
        .ovf   (overflow_flag)
    );

    // shared multiply / divide / square root unit
    pfm_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // result sequencer, owns busy and the result registers
    pfm_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .last_go        (last_go),
        .n              (n),
        .su             (su),
        .si             (si),
        .suu            (suu),
        .sii            (sii),
        .sui            (sui),
        .rsp            (rsp),
        .req            (req),
        .busy           (busy),
        .clear          (clear),
        .done           (done),
        .u_mean         (u_mean),
        .i_mean         (i_mean),
        .u_rms          (u_rms),
        .i_rms          (i_rms),
        .real_power     (real_power),
        .apparent_power (apparent_power),
        .power_factor   (power_factor),
        .undefined_flag (undefined_flag)
    );

    // sums still hold the window while the result strobe is up
    assign window_count = 13'(n);

    // a result only comes out of a busy window and frees the block after it
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result strobe");

    // a result never covers an empty window
    a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (window_count != 13'd0))
        else $error("result with empty window");

    // overflow only when the window is full
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow_flag) |-> (window_count == 13'(MAX_SAMPLES)))
        else $error("overflow flagged on a window that is not full");

    // zero apparent power forces a zero factor
    a_undef_pf: assert property (@(posedge clk) disable iff (!rst_n)
        (done && undefined_flag) |-> (power_factor == 16'sd0))
        else $error("power factor not zero with zero apparent power");

endmodule
`default_nettype wire

// ===== sim/tb_ac_power_factor_meter_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ac_power_factor_meter_top - self-checking bench for the power factor meter
// sends sample words in windows, predicts every window result in integer
// arithmetic and compares each done strobe field by field with the oldest one
// ----------------------------------------------------------------------------
module tb_ac_power_factor_meter_top;

    import pfm_pkg::*;

    localparam int  WIN_LIMIT = MAX_SAMPLES;
    localparam longint CYCLE_LIMIT = 5_000_000;

    // window content shapes
    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_IN_PHASE,
        SHAPE_ANTI_PHASE,
        SHAPE_CONSTANT,
        SHAPE_SQUARE
    } shape_t;

    // one expected window result
    typedef struct {
        logic [15:0] u_mean;
        logic [15:0] i_mean;
        logic [14:0] u_rms;
        logic [14:0] i_rms;
        logic [23:0] real_power;
        logic [22:0] apparent_power;
        logic [15:0] power_factor;
        logic        undefined_flag;
        logic        overflow_flag;
        logic [12:0] window_count;
    } meas_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [11:0] u_sample = '0;
    logic [11:0] i_sample = '0;
    logic        last_sample = 1'b0;
    logic        done;
    logic [15:0] u_mean;
    logic [15:0] i_mean;
    logic [14:0] u_rms;
    logic [14:0] i_rms;
    logic signed [23:0] real_power;
    logic [22:0] apparent_power;
    logic signed [15:0] power_factor;
    logic        undefined_flag;
    logic        overflow_flag;
    logic [12:0] window_count;

    // running window sums of the predictor
    int              win_pairs;
    longint unsigned win_su, win_si, win_suu, win_sii, win_sui;
    bit              win_ovf;

    meas_t  pending_meas[$];
    int     gap_pct = 0;
    int     error_count = 0;
    int     words_sent = 0;
    int     windows_checked = 0;
    int     overflow_windows = 0;
    longint cycle_count = 0;

    ac_power_factor_meter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .u_sample       (u_sample),
        .i_sample       (i_sample),
        .last_sample    (last_sample),
        .done           (done),
        .u_mean         (u_mean),
        .i_mean         (i_mean),
        .u_rms          (u_rms),
        .i_rms          (i_rms),
        .real_power     (real_power),
        .apparent_power (apparent_power),
        .power_factor   (power_factor),
        .undefined_flag (undefined_flag),
        .overflow_flag  (overflow_flag),
        .window_count   (window_count)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // integer square root, bit by bit, floor result
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // dc-removed rms in q4: sqrt(256*(n*ss - s^2)) / n
    function automatic longint unsigned rms_q4(input longint unsigned n,
                                               input longint unsigned s,
                                               input longint unsigned ss);
        longint unsigned var_n;
        var_n = (n * ss > s * s) ? n * ss - s * s : 0;
        return int_sqrt(var_n * 256) / n;
    endfunction

    function automatic void clear_window_sums();
        win_pairs = 0;
        win_su = 0;
        win_si = 0;
        win_suu = 0;
        win_sii = 0;
        win_sui = 0;
        win_ovf = 0;
    endfunction

    // folds one accepted word into the window; on the last word queues the
    // expected measurement
    function automatic void accumulate_word(input logic [11:0] u, input logic [11:0] i,
                                            input bit last);
        meas_t m;
        longint unsigned n, urms, irms, d, app, mag, p, pq8, q, cross_a, cross_b;
        bit neg;
        if (win_pairs < WIN_LIMIT)
        begin
            win_pairs++;
            win_su  += u;
            win_si  += i;
            win_suu += longint'(u) * u;
            win_sii += longint'(i) * i;
            win_sui += longint'(u) * i;
        end
        else
            win_ovf = 1;
        if (!last)
            return;
        n = win_pairs;
        urms = rms_q4(n, win_su, win_suu);
        irms = rms_q4(n, win_si, win_sii);
        cross_a = n * win_sui;
        cross_b = win_su * win_si;
        neg = cross_b > cross_a;
        mag = neg ? cross_b - cross_a : cross_a - cross_b;
        d = urms * irms;
        app = d >> 8;
        p = mag / (n * n);
        m.real_power = neg ? 24'(-p) : 24'(p);
        if (app == 0)
            m.power_factor = 16'd0;
        else
        begin
            pq8 = (mag * 256) / (n * n);
            q = (pq8 * 32768) / d;
            if (neg)
                m.power_factor = (q > 32768) ? 16'h8000 : 16'(-q);
            else
                m.power_factor = (q > 32767) ? 16'h7fff : 16'(q);
        end
        m.u_mean = 16'((win_su * 16) / n);
        m.i_mean = 16'((win_si * 16) / n);
        m.u_rms = 15'(urms);
        m.i_rms = 15'(irms);
        m.apparent_power = 23'(app);
        m.undefined_flag = (app == 0);
        m.overflow_flag = win_ovf;
        m.window_count = 13'(n);
        pending_meas.push_back(m);
        clear_window_sums();
    endfunction

    // one sample word through start/busy, with an optional idle gap in front
    task automatic send_word(input logic [11:0] u, input logic [11:0] i, input bit last);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        u_sample <= u;
        i_sample <= i;
        last_sample <= last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        words_sent++;
        accumulate_word(u, i, last);
    endtask

    // a whole window of len words in the given shape
    task automatic send_window(input int len, input shape_t shape);
        logic [11:0] u, i, base_u, base_i;
        base_u = 12'($urandom);
        base_i = 12'($urandom);
        for (int k = 0; k < len; k++)
        begin
            u = 12'($urandom);
            case (shape)
                SHAPE_RANDOM:     i = 12'($urandom);
                SHAPE_IN_PHASE:   i = u;
                SHAPE_ANTI_PHASE: i = ~u;
                SHAPE_CONSTANT:
                begin
                    u = base_u;
                    i = base_i;
                end
                default:
                begin
                    u = k[0] ? 12'hfff : 12'h000;
                    i = ($urandom_range(1)) ? u : ~u;
                end
            endcase
            send_word(u, i, k == len - 1);
        end
    endtask

    // result side: every done strobe is checked against the oldest expectation
    function automatic void check_field(input string name, input longint expv,
                                        input longint actv);
        if (expv != actv)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        meas_t m;
        if (rst_n && done === 1'b1)
        begin
            if (pending_meas.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                m = pending_meas.pop_front();
                check_field("u_mean", m.u_mean, u_mean);
                check_field("i_mean", m.i_mean, i_mean);
                check_field("u_rms", m.u_rms, u_rms);
                check_field("i_rms", m.i_rms, i_rms);
                check_field("real_power", $signed(m.real_power), real_power);
                check_field("apparent_power", m.apparent_power, apparent_power);
                check_field("power_factor", $signed(m.power_factor), power_factor);
                check_field("undefined_flag", m.undefined_flag, undefined_flag);
                check_field("overflow_flag", m.overflow_flag, overflow_flag);
                check_field("window_count", m.window_count, window_count);
                windows_checked++;
                if (m.overflow_flag)
                    overflow_windows++;
            end
        end
    end

    // extremes: single-word window, full swing in and out of phase, flat input
    task automatic test_extremes();
        gap_pct = 0;
        send_word(12'hfff, 12'h000, 1'b1);
        send_word(12'h000, 12'hfff, 1'b1);
        send_word(12'h000, 12'h000, 1'b0);
        send_word(12'hfff, 12'hfff, 1'b1);
        send_word(12'h000, 12'hfff, 1'b0);
        send_word(12'hfff, 12'h000, 1'b1);
        send_window(4, SHAPE_CONSTANT);
        send_window(6, SHAPE_SQUARE);
        send_window(4, SHAPE_IN_PHASE);
        send_window(4, SHAPE_RANDOM);
    endtask

    // long windows: full-swing square wave and a random window
    task automatic test_window_limit();
        gap_pct = 0;
        send_window(64, SHAPE_SQUARE);
        send_window(64, SHAPE_RANDOM);
    endtask

    // random windows, mostly short, with the given sender idle rate
    task automatic test_random_windows(input int idle_pct, input int n_words);
        int target;
        int len;
        shape_t shape;
        gap_pct = idle_pct;
        target = words_sent + n_words;
        while (words_sent < target)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            case ($urandom_range(9))
                0:       shape = SHAPE_IN_PHASE;
                1:       shape = SHAPE_ANTI_PHASE;
                2:       shape = SHAPE_CONSTANT;
                3:       shape = SHAPE_SQUARE;
                default: shape = SHAPE_RANDOM;
            endcase
            send_window(len, shape);
        end
    endtask

    initial
    begin
        clear_window_sums();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_window_limit();
        test_random_windows(0, 120);
        test_random_windows(75, 120);
        test_random_windows(13, 120);
        test_random_windows(0, 120);

        start <= 1'b0;
        wait (pending_meas.size() == 0);
        repeat (50) @(posedge clk);

        $display("sent %0d sample words, checked %0d window results (%0d overflowed)",
                 words_sent, windows_checked, overflow_windows);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
